// File: src/tmean_pkg.sv
// tmean_pkg: shared widths, register indexes and reset values for the
// trimmed mean block. No dependencies.

package tmean_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_W     = 8;
  localparam int MEAN_W     = 20;

  localparam int MAX_SAMPLES_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CUT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_CUT     = 2'd2;

  localparam logic [CFG_W-1:0] BURST_LENGTH_RST = 7'd16;
  localparam logic [CFG_W-1:0] LOW_CUT_RST      = 7'd2;
  localparam logic [CFG_W-1:0] HIGH_CUT_RST     = 7'd2;

endpackage

// File: src/tmean_if.sv
// tmean_if: valid/ready channel interfaces for samples, results and
// register writes. Depends on tmean_pkg.

interface sample_if import tmean_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface result_if import tmean_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_q8;
  logic              bad_cutoff;

  modport source (output valid, output mean_q8, output bad_cutoff, input ready);
  modport sink   (input valid, input mean_q8, input bad_cutoff, output ready);
endinterface

interface cfg_if import tmean_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/tmean_store.sv
// tmean_store: sorted sample memory, one write port and one read port
// with registered read data. Depends on tmean_pkg.

module tmean_store import tmean_pkg::*; #(
  parameter int DEPTH = MAX_SAMPLES_DEF,
  parameter int AW    = $clog2(MAX_SAMPLES_DEF)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/tmean_div.sv
// tmean_div: restoring divider, one quotient bit per cycle.
// Depends on tmean_pkg.

module tmean_div import tmean_pkg::*; #(
  parameter int DW = 34,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [VW:0]   trial;
  logic          fits;

  assign trial    = {rem, quo[DW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? VW'(trial - {1'b0, dvs}) : VW'(trial);
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule

// File: src/trimmed_mean_of_sorted_samples.sv
// trimmed_mean_of_sorted_samples: top level, insertion and sum sequencer.
// Depends on tmean_pkg, tmean_if, tmean_store and tmean_div.
//
// Usage: samples (sink) takes one 12-bit converter sample per beat; results
// (source) gives one beat per completed burst with mean_q8 (8 fraction bits,
// truncated) and bad_cutoff; cfg takes register writes (index 0 burst_length,
// 1 low_cut, 2 high_cut) and is always ready, to be used while the block idles.
// Each sample is inserted into a sorted memory by walking down from the top
// entry, one shifted entry per cycle, then passes a check state. The sample
// that completes a burst then sums the kept entries in a memory read loop,
// divides the sum by the kept count in the bit-serial divider and loads the
// output register. A burst whose cutoffs keep nothing gives zero with
// bad_cutoff straight from the check state.
// The result sits in an output register: while it waits the block still takes
// samples, and stalls only when a new result is ready and the register is full.
// Reset empties the burst, clears the output and restores the register
// defaults (16, 2, 2); the memory itself is not cleared.

module trimmed_mean_of_sorted_samples import tmean_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  cfg_if.sink      cfg,
  sample_if.sink   samples,
  result_if.source results
);

  localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int DVD_W = SUM_W + FRAC_W;
  localparam int CW    = (CNT_W > CFG_W + 1) ? CNT_W : CFG_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WALK  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t              state;
  logic [CFG_W-1:0]    burst_length;
  logic [CFG_W-1:0]    low_cut;
  logic [CFG_W-1:0]    high_cut;
  logic [SAMPLE_W-1:0] key;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    stop;
  logic [CNT_W-1:0]    kept;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic [MEAN_W-1:0]   pend_mean;
  logic                pend_bad;
  logic                res_valid;
  logic [MEAN_W-1:0]   res_mean;
  logic                res_bad;

  logic                in_acc;
  logic [CW-1:0]       eff_len;
  logic [CW-1:0]       fill_cw;
  logic [CW-1:0]       cut_sum;
  logic                burst_done;
  logic                cut_bad;
  logic                walk_stop;
  logic                sum_last;
  logic                emit_fire;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] rd_data;

  logic                div_start;
  logic                div_done;
  logic [DVD_W-1:0]    quo;

  assign cfg.ready          = 1'b1;
  assign samples.ready      = (state == ST_IDLE);
  assign in_acc             = samples.valid && samples.ready;
  assign results.valid      = res_valid;
  assign results.mean_q8    = res_mean;
  assign results.bad_cutoff = res_bad;

  always_comb begin
    eff_len = CW'(burst_length);
    if (eff_len == '0) begin
      eff_len = CW'(1);
    end else if (eff_len > CW'(MAX_SAMPLES)) begin
      eff_len = CW'(MAX_SAMPLES);
    end
  end

  assign fill_cw    = CW'(fill);
  assign cut_sum    = CW'(low_cut) + CW'(high_cut);
  assign burst_done = fill_cw >= eff_len;
  assign cut_bad    = cut_sum >= fill_cw;
  assign walk_stop  = (pos == '0) || (rd_data <= key);
  assign sum_last   = (idx + CNT_W'(1)) == stop;
  assign sum_next   = sum + SUM_W'(rd_data);
  assign div_start  = (state == ST_SUM) && sum_last;
  assign emit_fire  = (state == ST_EMIT) && (!res_valid || results.ready);

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(pos);
    wr_data = key;
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      ST_IDLE: begin
        rd_en   = in_acc && (fill != '0);
        rd_addr = AW'(fill - CNT_W'(1));
      end
      ST_WALK: begin
        wr_en = 1'b1;
        if (!walk_stop) begin
          wr_data = rd_data;
          rd_en   = (pos != CNT_W'(1));
          rd_addr = AW'(pos - CNT_W'(2));
        end
      end
      ST_CHECK: begin
        rd_en   = burst_done && !cut_bad;
        rd_addr = AW'(low_cut);
      end
      ST_SUM: begin
        rd_en   = !sum_last;
        rd_addr = AW'(idx + CNT_W'(1));
      end
      ST_DIV, ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      res_valid    <= 1'b0;
      burst_length <= BURST_LENGTH_RST;
      low_cut      <= LOW_CUT_RST;
      high_cut     <= HIGH_CUT_RST;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_BURST_LENGTH: burst_length <= cfg.data;
          REG_LOW_CUT:      low_cut      <= cfg.data;
          REG_HIGH_CUT:     high_cut     <= cfg.data;
          default: begin
          end
        endcase
      end
      if (emit_fire) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_stop) begin
            fill  <= fill + CNT_W'(1);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!burst_done) begin
            state <= ST_IDLE;
          end else begin
            fill <= '0;
            state <= cut_bad ? ST_EMIT : ST_SUM;
          end
        end
        ST_SUM: begin
          if (sum_last) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          key <= samples.sample;
          pos <= fill;
        end
      end
      ST_WALK: begin
        if (!walk_stop) begin
          pos <= pos - CNT_W'(1);
        end
      end
      ST_CHECK: begin
        idx       <= CNT_W'(low_cut);
        stop      <= CNT_W'(fill_cw - CW'(high_cut));
        kept      <= CNT_W'(fill_cw - cut_sum);
        sum       <= '0;
        pend_mean <= '0;
        pend_bad  <= 1'b1;
      end
      ST_SUM: begin
        sum <= sum_next;
        idx <= idx + CNT_W'(1);
      end
      ST_DIV: begin
        if (div_done) begin
          pend_mean <= MEAN_W'(quo);
          pend_bad  <= 1'b0;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          res_mean <= pend_mean;
          res_bad  <= pend_bad;
        end
      end
      default: begin
      end
    endcase
  end

  tmean_store #(
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tmean_div #(
    .DW (DVD_W),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_next, {FRAC_W{1'b0}}}),
    .divisor  (kept),
    .done     (div_done),
    .quotient (quo)
  );

  assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide phase");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) && !burst_done |=> (fill == $past(fill)))
    else $error("partial burst count lost");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_bad |-> (res_mean == '0))
    else $error("bad cutoff result with nonzero mean");

endmodule

// File: tb/trimmed_mean_of_sorted_samples_tb.sv
`timescale 1ns / 1ps
// trimmed_mean_of_sorted_samples_tb: self-checking bench for the trimmed mean block,
// with a predicted sorted burst per configuration and random beat gaps on both sides.
// Depends on tmean_pkg, tmean_if and trimmed_mean_of_sorted_samples.

module trimmed_mean_of_sorted_samples_tb;
  import tmean_pkg::*;

  localparam int MAX_SAMPLES   = MAX_SAMPLES_DEF;
  localparam int SETTLE_CYCLES = 260;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 550;

  localparam logic [SAMPLE_W-1:0] OPENING [16] = '{
    12'hFFF, 12'h000, 12'hAAA, 12'h555, 12'h800, 12'h7FF, 12'h001, 12'hFFE,
    12'h123, 12'h123, 12'hFFF, 12'h000, 12'h400, 12'h3FF, 12'hC00, 12'h001
  };

  typedef struct packed {
    logic [MEAN_W-1:0] mean_q8;
    logic              bad_cutoff;
  } burst_mean_t;

  class burst_scoreboard;
    logic [CFG_W-1:0]    burst_length;
    logic [CFG_W-1:0]    low_cut;
    logic [CFG_W-1:0]    high_cut;
    logic [SAMPLE_W-1:0] sorted_store [MAX_SAMPLES];
    int                  fill;
    burst_mean_t         expected_means [$];
    int                  mismatches;

    function new();
      burst_length = BURST_LENGTH_RST;
      low_cut      = LOW_CUT_RST;
      high_cut     = HIGH_CUT_RST;
      fill         = 0;
      mismatches   = 0;
    endfunction

    function int span(int len);
      if (len == 0) return 1;
      if (len > MAX_SAMPLES) return MAX_SAMPLES;
      return len;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_BURST_LENGTH: burst_length = val;
        REG_LOW_CUT:      low_cut = val;
        REG_HIGH_CUT:     high_cut = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
      int              pos;
      int              held;
      int              lo;
      int              hi;
      longint unsigned total;
      burst_mean_t     m;
      pos = fill;
      if (pos < MAX_SAMPLES) begin
        while (pos > 0 && sorted_store[pos-1] > s) begin
          sorted_store[pos] = sorted_store[pos-1];
          pos--;
        end
        sorted_store[pos] = s;
        fill++;
      end
      if (fill < span(int'(burst_length))) return;
      held = fill;
      fill = 0;
      lo   = int'(low_cut);
      hi   = int'(high_cut);
      if (lo + hi >= held) begin
        m.mean_q8    = '0;
        m.bad_cutoff = 1'b1;
      end else begin
        total = 0;
        for (int i = lo; i < held - hi; i++) total += sorted_store[i];
        m.mean_q8    = MEAN_W'((total << FRAC_W) / longint'(held - lo - hi));
        m.bad_cutoff = 1'b0;
      end
      expected_means.push_back(m);
    endfunction

    function void check_result(burst_mean_t got);
      burst_mean_t want;
      if (expected_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: mean_q8 %0d bad_cutoff %0b",
                   got.mean_q8, got.bad_cutoff);
        return;
      end
      want = expected_means.pop_front();
      if (got.mean_q8 !== want.mean_q8 || got.bad_cutoff !== want.bad_cutoff) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected mean_q8 %0d bad_cutoff %0b, got %0d %0b",
                   want.mean_q8, want.bad_cutoff, got.mean_q8, got.bad_cutoff);
      end
    endfunction

    function int pending();
      return expected_means.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  sample_if sample_bus ();
  result_if result_bus ();
  cfg_if    cfg_bus ();

  burst_scoreboard board = new();

  bit                  started;
  bit                  steady;
  int                  stall_asks;
  int                  stall_served;
  int                  cycle_count;
  logic [SAMPLE_W-1:0] last_drawn;

  trimmed_mean_of_sorted_samples #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .samples(sample_bus),
    .results(result_bus)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int idle_gap();
    if (steady) return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0:       last_drawn = '0;
      1:       last_drawn = '1;
      2:       last_drawn = last_drawn;
      default: last_drawn = SAMPLE_W'($urandom_range(0, 4095));
    endcase
    return last_drawn;
  endfunction

  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= s;
    do @(posedge clk); while (!sample_bus.ready);
    board.note_sample(s);
  endtask

  task automatic end_samples();
    sample_bus.valid <= 1'b0;
  endtask

  task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    board.set_reg(idx, val);
  endtask

  task automatic write_config(int len, int lo, int hi);
    cfg_beat(REG_BURST_LENGTH, CFG_W'(len));
    cfg_beat(REG_LOW_CUT, CFG_W'(lo));
    cfg_beat(REG_HIGH_CUT, CFG_W'(hi));
    cfg_bus.valid <= 1'b0;
  endtask

  // drain results, then let a partly filled insertion walk finish
  task automatic settle();
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int          gap;
    burst_mean_t got;
    result_bus.ready <= 1'b0;
    wait (started);
    forever begin
      if (stall_asks != stall_served) begin
        result_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        stall_served++;
      end
      gap = idle_gap();
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      got.mean_q8    = result_bus.mean_q8;
      got.bad_cutoff = result_bus.bad_cutoff;
      board.check_result(got);
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    int eff;
    int lo;
    int hi;
    int count;
    int pick;
    rst               <= 1'b1;
    sample_bus.valid  <= 1'b0;
    sample_bus.sample <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= REG_BURST_LENGTH;
    cfg_bus.data      <= '0;
    last_drawn        = '0;
    repeat (9) @(posedge clk);
    rst     <= 1'b0;
    started = 1'b1;

    // reset defaults, field extremes, duplicates
    foreach (OPENING[i]) send_sample(OPENING[i]);
    end_samples();
    settle();

    // zero burst length acts as one
    write_config(0, 0, 0);
    send_sample(12'hFFF);
    end_samples();
    settle();

    // cutoffs equal to the burst
    write_config(1, 1, 0);
    send_sample(12'h5A5);
    end_samples();
    settle();

    // cutoffs at their maximum
    write_config(3, 127, 127);
    send_sample(12'h010);
    send_sample(12'hF0F);
    send_sample(12'h777);
    end_samples();
    settle();

    // burst shortened with two samples held
    write_config(4, 1, 1);
    send_sample(12'h900);
    send_sample(12'h0FF);
    end_samples();
    settle();
    write_config(1, 1, 1);
    send_sample(12'h456);
    end_samples();
    settle();

    // one result per sample while the sink holds off
    steady = 1'b1;
    write_config(1, 0, 0);
    stall_asks++;
    repeat (14) send_sample(draw_sample());
    end_samples();
    settle();
    steady = 1'b0;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 23);
      if (pick == 0) len = 0;
      else if (pick == 1) len = 127;
      else if (pick == 2) len = 64;
      else if (pick <= 6) len = $urandom_range(13, 63);
      else len = $urandom_range(1, 12);
      eff  = board.span(len);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        lo = $urandom_range(0, 127);
        hi = $urandom_range(0, 127);
      end else if (pick == 1) begin
        lo = $urandom_range(0, eff);
        hi = eff - lo;
      end else if (pick == 2) begin
        lo = $urandom_range(0, eff - 1);
        hi = eff - 1 - lo;
      end else begin
        lo = $urandom_range(0, 3);
        hi = $urandom_range(0, 3);
      end
      steady = ($urandom_range(0, 3) == 0);
      settle();
      write_config(len, lo, hi);
      if (eff >= 40) count = eff;
      else count = eff * $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, eff);
      repeat (count) send_sample(draw_sample());
      end_samples();
      sent += count;
    end
    steady = 1'b0;
    settle();

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/tmean_pkg.sv
src/tmean_if.sv
src/tmean_store.sv
src/tmean_div.sv
src/trimmed_mean_of_sorted_samples.sv
tb/trimmed_mean_of_sorted_samples_tb.sv
